### design/sfd_pkg.sv
// Shared widths, types and character constants for the serial frame deframer.
package sfd_pkg;

   localparam int BYTE_W = 8;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_END     = 1'b1
   } kind_type;

   localparam byte_type CH_U     = 8'h55;
   localparam byte_type CH_N     = 8'h4E;
   localparam byte_type CH_E     = 8'h45;
   localparam byte_type CH_R     = 8'h52;
   localparam byte_type CH_COLON = 8'h3A;

   // Checksum seed before the length byte is folded in.
   localparam byte_type HDR_XOR  = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

endpackage

### design/sfd_if.sv
// Valid/ready channel interfaces for received bytes and deframer results.
interface sfd_req_if;
   import sfd_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_rsp_if;
   import sfd_pkg::*;

   logic     valid;
   logic     ready;
   kind_type kind;
   byte_type data_byte;
   byte_type position;
   byte_type frame_length;
   logic     checksum_ok;

   modport source (output valid, output kind, output data_byte, output position,
                   output frame_length, output checksum_ok, input ready);
   modport sink   (input valid, input kind, input data_byte, input position,
                   input frame_length, input checksum_ok, output ready);
endinterface

### design/serial_frame_deframer_xor.sv
// Serial frame deframer: header hunt, payload pass-through and XOR checksum check.
//
//  channel    dir  handshake        payload
//  req_chan   in   valid / ready    rx_byte
//  rsp_chan   out  valid / ready    kind, data_byte, position, frame_length, checksum_ok
//
//  One byte per cycle sustained while the result side is ready. A byte is held in
//  the input register and its result, if any, moves to the result register once that is free.
//  Reset returns the parser to hunting for the first header byte and empties both
//  registers. A stalled result holds the result register; the input register
//  still fills, so the block stops taking bytes only when both are occupied.
module serial_frame_deframer_xor (
   input logic        clock,
   input logic        reset,
   sfd_req_if.sink    req_chan,
   sfd_rsp_if.source  rsp_chan
);
   import sfd_pkg::*;

   typedef enum logic [2:0] {
      PH_U       = 3'd0,
      PH_N       = 3'd1,
      PH_E       = 3'd2,
      PH_R       = 3'd3,
      PH_LEN     = 3'd4,
      PH_TOKEN   = 3'd5,
      PH_PAYLOAD = 3'd6
   } phase_type;

   // input register
   logic      in_valid_ff, in_valid_in;
   byte_type  in_byte_ff;

   // parser state
   phase_type phase_ff, phase_in;
   byte_type  left_ff, left_in;
   byte_type  xor_ff, xor_in;
   byte_type  pos_ff, pos_in;
   byte_type  len_ff, len_in;

   // result register
   logic      out_valid_ff, out_valid_in;
   kind_type  out_kind_ff;
   byte_type  out_data_ff;
   byte_type  out_pos_ff;
   byte_type  out_len_ff;
   logic      out_ok_ff;

   // result of the byte in the input register
   logic      res_valid;
   kind_type  res_kind;
   byte_type  res_data;
   byte_type  res_pos;
   logic      res_ok;

   logic      out_free;
   logic      advance;
   phase_type restart;

   assign out_free         = !out_valid_ff || rsp_chan.ready;
   assign advance          = in_valid_ff && out_free;
   assign req_chan.ready   = !in_valid_ff || out_free;
   assign in_valid_in      = req_chan.valid || (in_valid_ff && !out_free);
   assign out_valid_in     = advance ? res_valid : (out_valid_ff && !rsp_chan.ready);

   // a mismatching byte is tested again as a first header byte
   assign restart = (in_byte_ff == CH_U) ? PH_N : PH_U;

   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      xor_in    = xor_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      res_valid = 1'b0;
      res_kind  = KIND_PAYLOAD;
      res_data  = '0;
      res_pos   = '0;
      res_ok    = 1'b0;
      unique case (phase_ff)
         PH_U: begin
            if (in_byte_ff == CH_U) phase_in = PH_N;
         end
         PH_N: begin
            phase_in = (in_byte_ff == CH_N) ? PH_E : restart;
         end
         PH_E: begin
            phase_in = (in_byte_ff == CH_E) ? PH_R : restart;
         end
         PH_R: begin
            phase_in = (in_byte_ff == CH_R) ? PH_LEN : restart;
         end
         PH_LEN: begin
            len_in   = in_byte_ff;
            left_in  = in_byte_ff;
            phase_in = PH_TOKEN;
         end
         PH_TOKEN: begin
            if (in_byte_ff == CH_COLON) begin
               xor_in   = HDR_XOR ^ len_ff;
               pos_in   = '0;
               phase_in = PH_PAYLOAD;
            end else begin
               phase_in = restart;
            end
         end
         PH_PAYLOAD: begin
            res_valid = 1'b1;
            if (left_ff > 8'd1) begin
               xor_in   = xor_ff ^ in_byte_ff;
               pos_in   = pos_ff + 8'd1;
               left_in  = left_ff - 8'd1;
               res_data = in_byte_ff;
               res_pos  = pos_ff + 8'd1;
            end else begin
               // checksum byte; a zero length lands here too
               left_in  = '0;
               phase_in = PH_U;
               res_kind = KIND_END;
               res_ok   = (xor_ff == in_byte_ff);
            end
         end
         default: begin
            phase_in = PH_U;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_U;
         left_ff      <= '0;
         xor_ff       <= '0;
         pos_ff       <= '0;
         len_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
            xor_ff   <= xor_in;
            pos_ff   <= pos_in;
            len_ff   <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance && res_valid) begin
         out_kind_ff <= res_kind;
         out_data_ff <= res_data;
         out_pos_ff  <= res_pos;
         out_len_ff  <= len_ff;
         out_ok_ff   <= res_ok;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = out_kind_ff;
   assign rsp_chan.data_byte    = out_data_ff;
   assign rsp_chan.position     = out_pos_ff;
   assign rsp_chan.frame_length = out_len_ff;
   assign rsp_chan.checksum_ok  = out_ok_ff;

endmodule

### tb/sv/deframer_checker.sv
`timescale 1ns / 100ps
// Deframer checker: predicts results from accepted bytes and compares them as they leave.
module deframer_checker
   import sfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sfd_req_if          req_mon,
   sfd_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned results_due
);

   typedef enum logic [2:0] {
      SEEK_U      = 3'd0,
      SEEK_N      = 3'd1,
      SEEK_E      = 3'd2,
      SEEK_R      = 3'd3,
      GET_LEN     = 3'd4,
      GET_TOKEN   = 3'd5,
      GET_BODY    = 3'd6,
      PHASE_SPARE = 3'd7
   } hunt_phase_type;

   typedef struct packed {
      kind_type kind;
      byte_type data_byte;
      byte_type position;
      byte_type frame_length;
      logic     checksum_ok;
   } frame_result_type;

   hunt_phase_type   hunt_phase = SEEK_U;
   byte_type         body_left  = '0;
   byte_type         sum_xor    = '0;
   byte_type         body_pos   = '0;
   byte_type         len_byte   = '0;
   frame_result_type due_results[$];
   int unsigned      mismatches = 0;
   int unsigned      due_count  = 0;

   assign fail_count  = mismatches;
   assign results_due = due_count;

   // A header or token miss tests the same byte again as a first header byte.
   function automatic hunt_phase_type restart_on(input byte_type b);
      return (b == CH_U) ? SEEK_N : SEEK_U;
   endfunction

   task automatic parse_rx_byte(input byte_type b);
      frame_result_type res;
      res = '0;
      case (hunt_phase)
         SEEK_U:    if (b == CH_U) hunt_phase = SEEK_N;
         SEEK_N:    hunt_phase = (b == CH_N) ? SEEK_E : restart_on(b);
         SEEK_E:    hunt_phase = (b == CH_E) ? SEEK_R : restart_on(b);
         SEEK_R:    hunt_phase = (b == CH_R) ? GET_LEN : restart_on(b);
         GET_LEN: begin
            len_byte   = b;
            body_left  = b;
            hunt_phase = GET_TOKEN;
         end
         GET_TOKEN: begin
            if (b == CH_COLON) begin
               sum_xor    = HDR_XOR ^ len_byte;
               body_pos   = '0;
               hunt_phase = GET_BODY;
            end else begin
               hunt_phase = restart_on(b);
            end
         end
         GET_BODY: begin
            res.frame_length = len_byte;
            if (body_left > 8'd1) begin
               sum_xor       = sum_xor ^ b;
               body_pos      = body_pos + 8'd1;
               body_left     = body_left - 8'd1;
               res.kind      = KIND_PAYLOAD;
               res.data_byte = b;
               res.position  = body_pos;
            end else begin
               // checksum byte; a zero length lands here straight after the token
               body_left       = '0;
               hunt_phase      = SEEK_U;
               res.kind        = KIND_END;
               res.checksum_ok = (sum_xor == b);
            end
            due_results.push_back(res);
         end
         default:   hunt_phase = SEEK_U;
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         hunt_phase = SEEK_U;
         body_left  = '0;
         sum_xor    = '0;
         body_pos   = '0;
         len_byte   = '0;
         due_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual %0d %0h %0d %0d %0b",
                        $time, rsp_mon.kind, rsp_mon.data_byte, rsp_mon.position,
                        rsp_mon.frame_length, rsp_mon.checksum_ok);
            end else begin
               want = due_results.pop_front();
               check_field("kind", want.kind, rsp_mon.kind);
               check_field("data_byte", want.data_byte, rsp_mon.data_byte);
               check_field("position", want.position, rsp_mon.position);
               check_field("frame_length", want.frame_length, rsp_mon.frame_length);
               check_field("checksum_ok", want.checksum_ok, rsp_mon.checksum_ok);
            end
         end
         if (req_mon.valid && req_mon.ready) parse_rx_byte(req_mon.rx_byte);
      end
      due_count <= due_results.size();
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, byte stimulus, result back-pressure and the verdict.
module tb;
   import sfd_pkg::*;

   localparam int LONG_HOLD    = 150;
   localparam int TARGET_ITEMS = 550;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned fail_count;
   int unsigned results_due;
   int unsigned frame_items  = 0;
   bit          burst_mode   = 1'b0;
   bit          hold_request = 1'b0;

   sfd_req_if req_chan ();
   sfd_rsp_if rsp_chan ();

   serial_frame_deframer_xor i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   deframer_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("serial_frame_deframer_xor test failed");
      $finish;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic byte_type header_byte(input int unsigned idx);
      case (idx)
         0:       return CH_U;
         1:       return CH_N;
         2:       return CH_E;
         default: return CH_R;
      endcase
   endfunction

   task automatic send_byte(input byte_type b, input bit counted);
      int unsigned gap;
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      if (counted) frame_items++;
      gap = burst_mode ? 0 : pick_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the input idle until every predicted result has left the block.
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   task automatic send_frame(input byte_type len, input bit good);
      byte_type    sum;
      byte_type    b;
      int unsigned body;
      sum  = HDR_XOR ^ len;
      body = (len == 0) ? 0 : len - 1;
      for (int i = 0; i < 4; i++) send_byte(header_byte(i), 1'b1);
      send_byte(len, 1'b1);
      send_byte(CH_COLON, 1'b1);
      repeat (body) begin
         b   = byte_type'($urandom_range(255));
         sum = sum ^ b;
         send_byte(b, 1'b1);
      end
      if (!good) sum = sum ^ byte_type'($urandom_range(255, 1));
      send_byte(sum, 1'b1);
   endtask

   // Header cut short by a wrong byte, or a full header with a bad token.
   task automatic send_broken();
      int unsigned depth;
      byte_type    b;
      byte_type    due;
      depth = $urandom_range(4);
      for (int i = 0; i < depth && i < 4; i++) send_byte(header_byte(i), 1'b0);
      if (depth == 4) begin
         send_byte(byte_type'($urandom_range(255)), 1'b0);
         due = CH_COLON;
      end else begin
         due = header_byte(depth);
      end
      if (due != CH_U && $urandom_range(3) == 0) begin
         b = CH_U;
      end else begin
         do b = byte_type'($urandom_range(255)); while (b == due);
      end
      send_byte(b, 1'b0);
   endtask

   initial begin
      byte_type    opening_bytes[$];
      byte_type    len;
      int unsigned roll;
      bit          big_done;
      big_done = 1'b0;
      opening_bytes = '{
         // zero length: the byte after the token is the checksum
         CH_U, CH_N, CH_E, CH_R, 8'h00, CH_COLON, HDR_XOR,
         // second 'U' breaks the header and starts it again
         CH_U, CH_U, CH_N, CH_E, CH_R, 8'h03, CH_COLON, 8'h00, 8'hFF,
         HDR_XOR ^ 8'h03 ^ 8'hFF,
         // 'U' in the token slot restarts the hunt; frame ends with a bad checksum
         CH_U, CH_N, CH_E, CH_R, 8'h01, CH_U, CH_N, CH_E, CH_R, 8'h01, CH_COLON,
         ~(HDR_XOR ^ 8'h01)
      };
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_bytes[i]) send_byte(opening_bytes[i], 1'b1);
      drain();

      while (frame_items < TARGET_ITEMS) begin
         roll       = $urandom_range(99);
         burst_mode = ($urandom_range(9) < 2);
         if (roll < 8) begin
            send_byte(byte_type'($urandom_range(255)), 1'b0);
         end else if (roll < 18) begin
            send_broken();
         end else begin
            if (!big_done && frame_items > 200) begin
               // longest frame, offered against a long receiver hold-off
               big_done     = 1'b1;
               hold_request = 1'b1;
               len          = 8'd255;
            end else if (roll < 70) begin
               len = byte_type'($urandom_range(6));
            end else if (roll < 94) begin
               len = byte_type'($urandom_range(24, 7));
            end else begin
               len = byte_type'($urandom_range(60, 25));
            end
            if ($urandom_range(29) == 0) drain();
            send_frame(len, $urandom_range(4) != 0);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && results_due == 0) begin
         $display("serial_frame_deframer_xor test passed");
      end else begin
         $display("serial_frame_deframer_xor test failed");
      end
      $finish;
   end

   // Result side: random stalls and free-running stretches, plus one long hold-off.
   initial begin
      int unsigned stall_left;
      int unsigned free_left;
      stall_left     = 0;
      free_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (free_left != 0) begin
            free_left--;
            rsp_chan.ready <= 1'b1;
         end else if ($urandom_range(3) == 0) begin
            stall_left = pick_gap();
            rsp_chan.ready <= 1'b0;
         end else begin
            free_left = $urandom_range(12);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

endmodule
